@@ rtl/assert_macros.svh @@
// Assertion macros for the OSD bar pixel generator.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OSDBAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OSDBAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/osdbar_pkg.sv @@
// Shared types, codes, constants and font table of the OSD bar pixel generator.
// No dependencies.
package osdbar_pkg;

  localparam int LEFT_CHARS   = 16;
  localparam int CENTER_CHARS = 16;
  localparam int RIGHT_CHARS  = 24;

  localparam logic [7:0] LUMA_BG    = 8'd45;
  localparam logic [7:0] LUMA_LIT   = 8'd235;
  localparam logic [7:0] LUMA_TRACK = 8'd90;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7E;

  localparam logic [12:0] WIDTH_RESET = 13'd1024;

  typedef enum logic [2:0] {
    CFG_DISPLAY_WIDTH    = 3'd0,
    CFG_ICON_MODE        = 3'd1,
    CFG_PROGRESS_ENABLE  = 3'd2,
    CFG_PROGRESS_PERCENT = 3'd3,
    CFG_LEFT_LENGTH      = 3'd4,
    CFG_CENTER_LENGTH    = 3'd5,
    CFG_RIGHT_LENGTH     = 3'd6
  } cfg_index_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PIXEL = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    SLOT_LEFT   = 2'd0,
    SLOT_CENTER = 2'd1,
    SLOT_RIGHT  = 2'd2
  } slot_t;

  typedef enum logic [1:0] {
    ICON_NONE  = 2'd0,
    ICON_PLAY  = 2'd1,
    ICON_PAUSE = 2'd2
  } icon_t;

  // Per-stage load enables handed to each text lane.
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } stage_en_t;

  // One character write into a text store.
  typedef struct packed {
    logic       we;
    logic [4:0] pos;
    logic [7:0] code;
  } wr_t;

  // 5x7 font, one entry per printable code, packed {col0, col1, col2, col3, col4}.
  localparam logic [39:0] GLYPH [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  // Divide a value of at most 20 by three.
  function automatic logic [2:0] div3(input logic [4:0] v);
    logic [2:0] q;
    if (v >= 5'd18)      q = 3'd6;
    else if (v >= 5'd15) q = 3'd5;
    else if (v >= 5'd12) q = 3'd4;
    else if (v >= 5'd9)  q = 3'd3;
    else if (v >= 5'd6)  q = 3'd2;
    else if (v >= 5'd3)  q = 3'd1;
    else                 q = 3'd0;
    return q;
  endfunction

  // Font dot at column col (0..4) and row row (0..6); non-printable codes are dark.
  function automatic logic glyph_bit(input logic [7:0] code, input logic [2:0] col,
                                     input logic [2:0] row);
    logic [39:0] e;
    logic [7:0]  b;
    logic [7:0]  ofs;
    logic [2:0]  sh;
    ofs = code - CODE_FIRST;
    e   = GLYPH[ofs[6:0]];
    sh  = 3'd4 - col;
    b   = e[{sh, 3'b000} +: 8];
    return (code >= CODE_FIRST) && (code <= CODE_LAST) && b[row];
  endfunction

endpackage

@@ rtl/osdbar_text_lane.sv @@
// One text string: cell locate over two stages, character store, font lookup.
// Depends on osdbar_pkg.
module osdbar_text_lane #(
  parameter int DEPTH = osdbar_pkg::LEFT_CHARS
) (
  input  logic                  clk,
  input  osdbar_pkg::stage_en_t en,
  input  logic signed [14:0]    dx,
  input  logic [5:0]            len,
  input  osdbar_pkg::wr_t       wr,
  input  logic [2:0]            rrow,
  output logic                  lit
);
  localparam int AW   = $clog2(DEPTH);
  localparam int SPAN = 18 * DEPTH;

  logic [7:0] mem [DEPTH];

  logic [9:0]  dx2;
  logic        inr2;
  logic [19:0] prod3;
  logic [9:0]  dx3;
  logic        inr3;
  logic [7:0]  code4;
  logic [2:0]  col4;
  logic        ok4;

  logic [5:0] lenc;
  logic [5:0] idx;
  logic [9:0] wfull;
  logic [4:0] cell_ofs;
  logic       ok3;

  assign lenc     = (len > 6'(DEPTH)) ? 6'(DEPTH) : len;
  assign idx      = prod3[19:14];
  assign wfull    = dx3 - {idx, 4'b0000} - {3'b000, idx, 1'b0};
  assign cell_ofs = wfull[4:0];
  assign ok3      = inr3 && (idx < lenc) && (cell_ofs < 5'd15);

  always_ff @(posedge clk) begin
    if (en.en2) begin
      dx2  <= dx[9:0];
      inr2 <= !dx[14] && (dx < 15'(SPAN));
    end
    if (en.en3) begin
      // floor(dx / 18) as (dx * 911) >> 14, exact for dx below 576
      prod3 <= {10'b0, dx2} * 20'd911;
      dx3   <= dx2;
      inr3  <= inr2;
    end
    if (en.en4) begin
      code4 <= mem[idx[AW-1:0]];
      col4  <= osdbar_pkg::div3(cell_ofs);
      ok4   <= ok3;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.pos[AW-1:0]] <= wr.code;
    end
  end

  assign lit = ok4 && osdbar_pkg::glyph_bit(code4, col4, rrow);

endmodule

@@ rtl/osd_bar_pixel_generator.sv @@
// Top level of the OSD bar pixel generator: handshake, configuration, pipeline.
// Depends on osdbar_pkg, osdbar_text_lane and assert_macros.svh.
//
// Pixel generator for a 60-row on-screen-display bar. Each input transaction
// either stores one character into the left, center or right text store
// (req_type 0, no result) or renders one pixel (req_type 1, one luma result).
// The block takes one transaction per clock while the input is not stalled; a
// pixel's luma passes through the input register, stages 2 to 4 and the output
// register before it appears on the output, and it waits there while the output is
// stalled. Stage 1 places the text strings, icon and progress
// track; stage 2 runs the cell and progress-fill multipliers; stage 3 splits
// the pixel into character index and column and reads the text stores, where
// character writes also land, so writes and reads keep their order; stage 4
// looks up the font. Stall backs up stage by stage, so bubbles still fill while
// a finished result waits. Configuration writes take effect at once and are
// meant to be done with the pipeline empty.
`include "assert_macros.svh"

module osd_bar_pixel_generator #(
  parameter int LEFT_CHARS   = osdbar_pkg::LEFT_CHARS,
  parameter int CENTER_CHARS = osdbar_pkg::CENTER_CHARS,
  parameter int RIGHT_CHARS  = osdbar_pkg::RIGHT_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [1:0]  text_slot,
  input  logic [4:0]  char_pos,
  input  logic [7:0]  char_code,
  input  logic [11:0] pixel_x,
  input  logic [5:0]  pixel_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  luma
);

  // configuration registers
  logic [12:0] display_width;
  logic [1:0]  icon_mode;
  logic        progress_enable;
  logic [6:0]  progress_percent;
  logic [3:0]  left_length;
  logic [3:0]  center_length;
  logic [4:0]  right_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width    <= osdbar_pkg::WIDTH_RESET;
      icon_mode        <= osdbar_pkg::ICON_NONE;
      progress_enable  <= 1'b0;
      progress_percent <= 7'd0;
      left_length      <= 4'd0;
      center_length    <= 4'd0;
      right_length     <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        osdbar_pkg::CFG_DISPLAY_WIDTH:    display_width    <= cfg_data;
        osdbar_pkg::CFG_ICON_MODE:        icon_mode        <= cfg_data[1:0];
        osdbar_pkg::CFG_PROGRESS_ENABLE:  progress_enable  <= cfg_data[0];
        osdbar_pkg::CFG_PROGRESS_PERCENT: progress_percent <= cfg_data[6:0];
        osdbar_pkg::CFG_LEFT_LENGTH:      left_length      <= cfg_data[3:0];
        osdbar_pkg::CFG_CENTER_LENGTH:    center_length    <= cfg_data[3:0];
        osdbar_pkg::CFG_RIGHT_LENGTH:     right_length     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  logic v1, v2, v3, v4;
  logic req4;
  logic en1, en2, en3, en4, en_out;

  assign en_out   = !out_valid || !out_stall;
  assign en4      = !v4 || en_out;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1)    v1        <= in_valid;
      if (en2)    v2        <= v1;
      if (en3)    v3        <= v2;
      if (en4)    v4        <= v3;
      // drop write transactions here: they carry no result
      if (en_out) out_valid <= v4 && (req4 == osdbar_pkg::REQ_PIXEL);
    end
  end

  // ---------------- stage 1: registered input, geometry ----------------
  logic        req1;
  logic [1:0]  slot1;
  logic [4:0]  pos1;
  logic [7:0]  code1;
  logic [11:0] x1;
  logic [5:0]  y1;

  always_ff @(posedge clk) begin
    if (en1) begin
      req1  <= req_type;
      slot1 <= text_slot;
      pos1  <= char_pos;
      code1 <= char_code;
      x1    <= pixel_x;
      y1    <= pixel_y;
    end
  end

  logic [5:0]         nc, nr;
  logic [10:0]        n18c, n18r;
  logic signed [14:0] xs, ctr_v, ctr_sx, rt_v, rt_sx, lft_sx;
  logic signed [14:0] dx_l, dx_c, dx_r;
  logic               rok1;
  logic [5:0]         ry6;
  logic [2:0]         rrow1;
  logic [5:0]         dy;
  logic [11:0]        ix;
  logic               icon1;
  logic               clip1;
  logic signed [14:0] tw;
  logic [6:0]         pct;
  logic               bar1;
  logic [19:0]        pprod1;

  always_comb begin
    nc   = (6'(center_length) > 6'(CENTER_CHARS)) ? 6'(CENTER_CHARS) : 6'(center_length);
    nr   = (6'(right_length) > 6'(RIGHT_CHARS)) ? 6'(RIGHT_CHARS) : 6'(right_length);
    n18c = {1'b0, nc, 4'b0000} + {4'b0000, nc, 1'b0};
    n18r = {1'b0, nr, 4'b0000} + {4'b0000, nr, 1'b0};
    xs   = $signed({3'b000, x1});

    // center start: halve toward zero
    ctr_v  = $signed({2'b00, display_width}) - $signed({4'b0000, n18c});
    ctr_sx = (ctr_v + (ctr_v[14] ? 15'sd1 : 15'sd0)) >>> 1;
    // right start: 20 from the edge, clamp at zero
    rt_v   = $signed({2'b00, display_width}) - 15'sd20 - $signed({4'b0000, n18r});
    rt_sx  = rt_v[14] ? 15'sd0 : rt_v;
    lft_sx = (icon_mode != osdbar_pkg::ICON_NONE) ? 15'sd50 : 15'sd20;

    dx_l = xs - lft_sx;
    dx_c = xs - ctr_sx;
    dx_r = xs - rt_sx;

    rok1  = (y1 >= 6'd12) && (y1 < 6'd33);
    ry6   = y1 - 6'd12;
    rrow1 = osdbar_pkg::div3(ry6[4:0]);

    ix = x1 - 12'd20;
    dy = (y1 >= 6'd21) ? (y1 - 6'd21) : (6'd21 - y1);
    case (icon_mode)
      osdbar_pkg::ICON_NONE: icon1 = 1'b0;
      osdbar_pkg::ICON_PLAY: icon1 = (x1 >= 12'd20) && (x1 < 12'd38)
                                     && ({5'b0, dy, 1'b0} <= ix);
      default:               icon1 = (y1 >= 6'd12) && (y1 < 6'd30)
                                     && (((x1 >= 12'd20) && (x1 < 12'd26))
                                      || ((x1 >= 12'd32) && (x1 < 12'd38)));
    endcase

    clip1 = {1'b0, x1} >= display_width;

    // track spans x 20 up to display_width - 20
    tw     = $signed({2'b00, display_width}) - 15'sd40;
    pct    = (progress_percent > 7'd100) ? 7'd100 : progress_percent;
    bar1   = progress_enable && (y1 >= 6'd46) && (y1 < 6'd52) && !tw[14] && (tw != 15'sd0)
             && (x1 >= 12'd20) && ({1'b0, x1} < (display_width - 13'd20));
    pprod1 = {7'b0, tw[12:0]} * {13'b0, pct};
  end

  // ---------------- stage 2 ----------------
  logic        req2, bar2, clip2, icon2, rok2;
  logic [1:0]  slot2;
  logic [4:0]  pos2;
  logic [7:0]  code2;
  logic [11:0] x2;
  logic [2:0]  rrow2;
  logic [19:0] pprod2;

  always_ff @(posedge clk) begin
    if (en2) begin
      req2   <= req1;
      slot2  <= slot1;
      pos2   <= pos1;
      code2  <= code1;
      x2     <= x1;
      bar2   <= bar1;
      clip2  <= clip1;
      icon2  <= icon1;
      rok2   <= rok1;
      rrow2  <= rrow1;
      pprod2 <= pprod1;
    end
  end

  // ---------------- stage 3 ----------------
  logic        req3, bar3, clip3, icon3, rok3;
  logic [1:0]  slot3;
  logic [4:0]  pos3;
  logic [7:0]  code3;
  logic [11:0] x3;
  logic [2:0]  rrow3;
  logic [40:0] pq3;
  logic [12:0] fw3;
  logic        fill3;

  always_ff @(posedge clk) begin
    if (en3) begin
      req3  <= req2;
      slot3 <= slot2;
      pos3  <= pos2;
      code3 <= code2;
      x3    <= x2;
      bar3  <= bar2;
      clip3 <= clip2;
      icon3 <= icon2;
      rok3  <= rok2;
      rrow3 <= rrow2;
      // fill width = track * percent / 100 via reciprocal 2^27 / 100, rounded up
      pq3   <= {21'b0, pprod2} * 41'd1342178;
    end
  end

  assign fw3   = pq3[39:27];
  assign fill3 = {1'b0, x3} < (fw3 + 13'd20);

  // commit character writes as the transaction leaves stage 3
  logic            wr_go;
  osdbar_pkg::wr_t wr_l, wr_c, wr_r;

  assign wr_go = v3 && en4 && (req3 == osdbar_pkg::REQ_WRITE);

  always_comb begin
    wr_l.pos  = pos3;
    wr_l.code = code3;
    wr_l.we   = wr_go && (slot3 == osdbar_pkg::SLOT_LEFT) && ({1'b0, pos3} < 6'(LEFT_CHARS));
    wr_c.pos  = pos3;
    wr_c.code = code3;
    wr_c.we   = wr_go && (slot3 == osdbar_pkg::SLOT_CENTER)
                && ({1'b0, pos3} < 6'(CENTER_CHARS));
    wr_r.pos  = pos3;
    wr_r.code = code3;
    wr_r.we   = wr_go && (slot3 == osdbar_pkg::SLOT_RIGHT)
                && ({1'b0, pos3} < 6'(RIGHT_CHARS));
  end

  // ---------------- stage 4 ----------------
  logic       bar4, clip4, icon4, rok4, fill4;
  logic [2:0] rrow4;

  always_ff @(posedge clk) begin
    if (en4) begin
      req4  <= req3;
      bar4  <= bar3;
      clip4 <= clip3;
      icon4 <= icon3;
      rok4  <= rok3;
      rrow4 <= rrow3;
      fill4 <= fill3;
    end
  end

  osdbar_pkg::stage_en_t lane_en;
  logic                  lit_l, lit_c, lit_r;

  assign lane_en.en2 = en2;
  assign lane_en.en3 = en3;
  assign lane_en.en4 = en4;

  osdbar_text_lane #(.DEPTH(LEFT_CHARS)) u_left (
    .clk (clk), .en (lane_en), .dx (dx_l), .len ({2'b00, left_length}),
    .wr (wr_l), .rrow (rrow4), .lit (lit_l)
  );

  osdbar_text_lane #(.DEPTH(CENTER_CHARS)) u_center (
    .clk (clk), .en (lane_en), .dx (dx_c), .len ({2'b00, center_length}),
    .wr (wr_c), .rrow (rrow4), .lit (lit_c)
  );

  osdbar_text_lane #(.DEPTH(RIGHT_CHARS)) u_right (
    .clk (clk), .en (lane_en), .dx (dx_r), .len ({1'b0, right_length}),
    .wr (wr_r), .rrow (rrow4), .lit (lit_r)
  );

  // Final merge: clip first, then the progress bar over icon and text, then icon and text.
  logic [7:0] luma4;

  always_comb begin
    if (clip4)
      luma4 = osdbar_pkg::LUMA_BG;
    else if (bar4)
      luma4 = fill4 ? osdbar_pkg::LUMA_LIT : osdbar_pkg::LUMA_TRACK;
    else if (icon4 || (rok4 && (lit_l || lit_c || lit_r)))
      luma4 = osdbar_pkg::LUMA_LIT;
    else
      luma4 = osdbar_pkg::LUMA_BG;
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      luma <= luma4;
    end
  end

  // ---------------- assertions ----------------
  logic pix4, wr4_out, store_we, wr3_out;

  assign pix4     = v4 && (req4 == osdbar_pkg::REQ_PIXEL);
  assign wr4_out  = v4 && en_out && (req4 == osdbar_pkg::REQ_WRITE);
  assign store_we = wr_l.we || wr_c.we || wr_r.we;
  assign wr3_out  = v3 && en4 && (req3 == osdbar_pkg::REQ_WRITE);

  `OSDBAR_ASSERT_IMP(a_result_from_pixel, $rose(out_valid), $past(pix4), "result without pixel")
  `OSDBAR_ASSERT_IMP(a_take_when_empty, !v1, !in_stall, "input stalled with empty first stage")
  `OSDBAR_ASSERT_NXT(a_write_no_result, wr4_out, !out_valid, "write produced a result")
  `OSDBAR_ASSERT_IMP(a_write_needs_item, store_we, wr3_out, "store write without a write")

endmodule
